>>> src/rsa_pkg.sv
// Shared types and constants for the running statistics accumulator.
// Used by rsa_front, rsa_back and the top level; depends on nothing else.
package rsa_pkg;

    // Fixed field widths of the ports.
    localparam int SAMPLE_W = 24;
    localparam int COUNT_W  = 16;
    localparam int STD_W    = 23;

    // Internal accumulator and finishing datapath widths.
    localparam int TOTAL_W  = 40;
    localparam int SQ_W     = 63;
    localparam int PROD_W   = 79;
    localparam int DVSR_W   = 32;
    localparam int ROOT_W   = 64;
    localparam int ITER_W   = $clog2(PROD_W + 1);

    // Depth of the queue between the front and back parts (power of two).
    localparam int QDEPTH   = 4;

    // Defaults for the top-level parameters.
    localparam int DEF_SAMPLE_BITS = 24;
    localparam int DEF_COUNT_BITS  = 16;

    // Largest standard deviation that the output field can carry.
    localparam logic [STD_W-1:0] STD_MAX = {STD_W{1'b1}};

    // How the back part treats a queued transaction.
    typedef enum logic {
        KIND_SKIP = 1'b0,
        KIND_ADD  = 1'b1
    } rsa_kind_t;

    // One classified transaction as it sits in the queue.
    typedef struct packed {
        rsa_kind_t                   kind;
        logic                        last;
        logic signed [SAMPLE_W-1:0]  value;
    } rsa_item_t;

endpackage

>>> src/rsa_front.sv
// Front part: accepts input transactions, classifies them and queues them.
// Depends on rsa_pkg for the queued item type and queue depth.
module rsa_front #(
    parameter int SAMPLE_BITS = rsa_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rsa_pkg::SAMPLE_W-1:0]  sample,
    input  logic                          sample_missing,
    input  logic                          last_of_set,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    output rsa_pkg::rsa_item_t            item,
    output logic                          item_valid,
    input  logic                          item_pop
);
    import rsa_pkg::*;

    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int FILL_W = $clog2(QDEPTH + 1);

    rsa_item_t          q_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [FILL_W-1:0]  fill_reg;
    rsa_item_t          new_item;
    logic               push;
    logic               pop;

    // Classify the incoming transaction and sign-extend the used sample bits.
    always_comb
    begin
        new_item.kind  = sample_missing ? KIND_SKIP : KIND_ADD;
        new_item.last  = last_of_set;
        new_item.value = SAMPLE_W'($signed(sample[SAMPLE_BITS-1:0]));
    end

    assign sample_ready = (fill_reg != FILL_W'(QDEPTH));
    assign push         = sample_valid && sample_ready;
    assign item_valid   = (fill_reg != '0);
    assign pop          = item_pop && item_valid;
    assign item         = q_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

endmodule

>>> src/rsa_back.sv
// Back part: accumulates queued samples and, on the closing transaction,
// runs a shift-add multiplier, a restoring divider and a square root.
// Depends on rsa_pkg for widths and the queued item type.
module rsa_back #(
    parameter int SAMPLE_BITS = rsa_pkg::DEF_SAMPLE_BITS,
    parameter int COUNT_BITS  = rsa_pkg::DEF_COUNT_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rsa_pkg::rsa_item_t                   item,
    input  logic                                 item_valid,
    output logic                                 item_pop,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic [rsa_pkg::COUNT_W-1:0]          valid_count,
    output logic signed [rsa_pkg::SAMPLE_W-1:0]  mean_value,
    output logic [rsa_pkg::STD_W-1:0]            std_deviation,
    output logic signed [rsa_pkg::SAMPLE_W-1:0]  min_value,
    output logic signed [rsa_pkg::SAMPLE_W-1:0]  max_value,
    output logic                                 set_empty,
    output logic                                 count_saturated
);
    import rsa_pkg::*;

    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam logic signed [SAMPLE_W-1:0] SMAX_V =
        SAMPLE_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [SAMPLE_W-1:0] SMIN_V = -SMAX_V - SAMPLE_W'(1);

    typedef enum logic [7:0] {
        ST_RUN  = 8'b0000_0001,
        ST_MULA = 8'b0000_0010,
        ST_MULB = 8'b0000_0100,
        ST_DIFF = 8'b0000_1000,
        ST_DIVV = 8'b0001_0000,
        ST_SQRT = 8'b0010_0000,
        ST_DIVM = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    state_t                       state_reg, state_next;
    logic [COUNT_BITS-1:0]        count_reg, count_next;
    logic signed [TOTAL_W-1:0]    total_reg, total_next;
    logic [SQ_W-1:0]              sumsq_reg, sumsq_next;
    logic signed [SAMPLE_W-1:0]   min_reg, min_next;
    logic signed [SAMPLE_W-1:0]   max_reg, max_next;
    logic                         ovf_reg, ovf_next;

    logic [PROD_W-1:0]            acc_reg, acc_next;
    logic [PROD_W-1:0]            mcand_reg, mcand_next;
    logic [TOTAL_W-1:0]           mplier_reg, mplier_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;
    logic [ITER_W-1:0]            iter_reg, iter_next;
    logic [DVSR_W:0]              rem_reg, rem_next;
    logic [PROD_W-1:0]            quo_reg, quo_next;
    logic [DVSR_W-1:0]            dvsr_reg, dvsr_next;
    logic [ROOT_W-1:0]            x_reg, x_next;
    logic [ROOT_W-1:0]            root_reg, root_next;
    logic [ROOT_W-1:0]            bit_reg, bit_next;
    logic [STD_W-1:0]             std_reg, std_next;

    logic                         res_valid_reg;
    logic [COUNT_W-1:0]           o_count_reg;
    logic signed [SAMPLE_W-1:0]   o_mean_reg;
    logic [STD_W-1:0]             o_std_reg;
    logic signed [SAMPLE_W-1:0]   o_min_reg;
    logic signed [SAMPLE_W-1:0]   o_max_reg;
    logic                         o_empty_reg;
    logic                         o_sat_reg;

    logic                         load_out;
    logic [2*SAMPLE_W-1:0]        square;
    logic [TOTAL_W-1:0]           mag;
    logic [PROD_W-1:0]            acc_step;
    logic [PROD_W:0]              diff;
    logic [DVSR_W:0]              rem_shift;
    logic                         rem_ge;
    logic [DVSR_W:0]              rem_step;
    logic [PROD_W-1:0]            quo_step;
    logic [ROOT_W-1:0]            trial;
    logic                         root_ge;
    logic [ROOT_W-1:0]            root_step;
    logic [TOTAL_W-1:0]           mean_q;
    logic [TOTAL_W-1:0]           mean_s;

    // Shared datapath pieces.
    always_comb
    begin
        square    = $unsigned((2*SAMPLE_W)'(item.value) * (2*SAMPLE_W)'(item.value));
        mag       = total_reg[TOTAL_W-1] ? $unsigned(-total_reg) : $unsigned(total_reg);
        acc_step  = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
        diff      = {1'b0, prod_reg} - {1'b0, acc_reg};
        rem_shift = {rem_reg[DVSR_W-1:0], quo_reg[PROD_W-1]};
        rem_ge    = (rem_shift >= {1'b0, dvsr_reg});
        rem_step  = rem_ge ? rem_shift - {1'b0, dvsr_reg} : rem_shift;
        quo_step  = {quo_reg[PROD_W-2:0], rem_ge};
        trial     = root_reg + bit_reg;
        root_ge   = (x_reg >= trial);
        root_step = root_ge ? (root_reg >> 1) + bit_reg : (root_reg >> 1);
        mean_q    = quo_reg[TOTAL_W-1:0];
        mean_s    = total_reg[TOTAL_W-1] ? -mean_q : mean_q;
    end

    // Accumulation and finishing sequencer.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        sumsq_next  = sumsq_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        ovf_next    = ovf_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        iter_next   = iter_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvsr_next   = dvsr_reg;
        x_next      = x_reg;
        root_next   = root_reg;
        bit_next    = bit_reg;
        std_next    = std_reg;
        item_pop    = 1'b0;
        load_out    = 1'b0;

        unique case (state_reg)
            ST_RUN:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    if (item.kind == KIND_ADD)
                    begin
                        if (count_reg == CMAX)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + COUNT_BITS'(1);
                            total_next = total_reg + TOTAL_W'(item.value);
                            sumsq_next = sumsq_reg + SQ_W'(square);
                            if (item.value < min_reg)
                            begin
                                min_next = item.value;
                            end
                            if (item.value > max_reg)
                            begin
                                max_next = item.value;
                            end
                        end
                    end
                    if (item.last)
                    begin
                        state_next  = ST_MULA;
                        acc_next    = '0;
                        mcand_next  = PROD_W'(sumsq_next);
                        mplier_next = TOTAL_W'(count_next);
                        iter_next   = ITER_W'(COUNT_BITS);
                    end
                end
            end
            ST_MULA:
            begin
                acc_next    = acc_step;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                iter_next   = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    prod_next   = acc_step;
                    acc_next    = '0;
                    mcand_next  = PROD_W'(mag);
                    mplier_next = mag;
                    iter_next   = ITER_W'(TOTAL_W);
                    state_next  = ST_MULB;
                end
            end
            ST_MULB:
            begin
                acc_next    = acc_step;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                iter_next   = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                // Non-positive variance or fewer than two samples give zero.
                if (count_reg < COUNT_BITS'(2) || diff[PROD_W] || diff == '0)
                begin
                    x_next     = '0;
                    root_next  = '0;
                    bit_next   = ROOT_W'(1) << (ROOT_W - 2);
                    iter_next  = ITER_W'(ROOT_W / 2);
                    state_next = ST_SQRT;
                end
                else
                begin
                    quo_next   = diff[PROD_W-1:0];
                    rem_next   = '0;
                    dvsr_next  = DVSR_W'(count_reg) * (DVSR_W'(count_reg) - DVSR_W'(1));
                    iter_next  = ITER_W'(PROD_W);
                    state_next = ST_DIVV;
                end
            end
            ST_DIVV:
            begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    x_next     = quo_step[ROOT_W-1:0];
                    root_next  = '0;
                    bit_next   = ROOT_W'(1) << (ROOT_W - 2);
                    iter_next  = ITER_W'(ROOT_W / 2);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (root_ge)
                begin
                    x_next = x_reg - trial;
                end
                root_next = root_step;
                bit_next  = bit_reg >> 2;
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    std_next   = (root_step > ROOT_W'(STD_MAX)) ? STD_MAX
                                                                : root_step[STD_W-1:0];
                    quo_next   = {mag, (PROD_W - TOTAL_W)'(0)};
                    rem_next   = '0;
                    dvsr_next  = DVSR_W'(count_reg);
                    iter_next  = ITER_W'(TOTAL_W);
                    state_next = ST_DIVM;
                end
            end
            ST_DIVM:
            begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!res_valid_reg || result_ready)
                begin
                    load_out   = 1'b1;
                    count_next = '0;
                    total_next = '0;
                    sumsq_next = '0;
                    min_next   = SMAX_V;
                    max_next   = SMIN_V;
                    ovf_next   = 1'b0;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Control and accumulator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            count_reg     <= '0;
            total_reg     <= '0;
            sumsq_reg     <= '0;
            min_reg       <= SMAX_V;
            max_reg       <= SMIN_V;
            ovf_reg       <= 1'b0;
            iter_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            sumsq_reg <= sumsq_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            ovf_reg   <= ovf_next;
            iter_reg  <= iter_next;
            if (load_out)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Finishing datapath and output payload registers.
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvsr_reg   <= dvsr_next;
        x_reg      <= x_next;
        root_reg   <= root_next;
        bit_reg    <= bit_next;
        std_reg    <= std_next;
        if (load_out)
        begin
            o_count_reg <= COUNT_W'(count_reg);
            o_mean_reg  <= (count_reg == '0) ? '0 : mean_s[SAMPLE_W-1:0];
            o_std_reg   <= std_reg;
            o_min_reg   <= min_reg;
            o_max_reg   <= max_reg;
            o_empty_reg <= (count_reg == '0);
            o_sat_reg   <= ovf_reg;
        end
    end

    assign result_valid    = res_valid_reg;
    assign valid_count     = o_count_reg;
    assign mean_value      = o_mean_reg;
    assign std_deviation   = o_std_reg;
    assign min_value       = o_min_reg;
    assign max_value       = o_max_reg;
    assign set_empty       = o_empty_reg;
    assign count_saturated = o_sat_reg;

`ifndef ASSERT_OFF
    // A dropped sample can only happen once the count is full.
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == CMAX))
        else $error("overflow flag set while count not full");

    // Any accumulated sample keeps the minimum at or below the maximum.
    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("minimum above maximum");

    // Handing over a result leaves cleared state for the next set.
    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (count_reg == '0 && total_reg == '0 && !ovf_reg && result_valid))
        else $error("state not cleared after result");

    // The queue is drained only while accumulating.
    a_pop_run: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> (state_reg == ST_RUN && item_valid))
        else $error("pop outside accumulation");
`endif

endmodule

>>> src/running_statistics_accumulator.sv
// Throughput: one sample per cycle while a set is open; the queue holds four transactions.
// A closing transaction's result is computed in turn by the serial multiplier, a 79-step
// divider, a 32-step root and a 40-step divider (the 79-step divide is skipped when the
// variance is not positive).
// Reset: asynchronous, active low; clears the queue, the sums and the output valid.
module running_statistics_accumulator #(
    parameter int SAMPLE_BITS = rsa_pkg::DEF_SAMPLE_BITS,
    parameter int COUNT_BITS  = rsa_pkg::DEF_COUNT_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  logic [rsa_pkg::SAMPLE_W-1:0]         sample,
    input  logic                                 sample_missing,
    input  logic                                 last_of_set,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic [rsa_pkg::COUNT_W-1:0]          valid_count,
    output logic signed [rsa_pkg::SAMPLE_W-1:0]  mean_value,
    output logic [rsa_pkg::STD_W-1:0]            std_deviation,
    output logic signed [rsa_pkg::SAMPLE_W-1:0]  min_value,
    output logic signed [rsa_pkg::SAMPLE_W-1:0]  max_value,
    output logic                                 set_empty,
    output logic                                 count_saturated
);
    import rsa_pkg::*;

    rsa_item_t  item;
    logic       item_valid;
    logic       item_pop;

    // Intake and classification.
    rsa_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         (sample),
        .sample_missing (sample_missing),
        .last_of_set    (last_of_set),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .item           (item),
        .item_valid     (item_valid),
        .item_pop       (item_pop)
    );

    // Accumulation and statistics.
    rsa_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item),
        .item_valid      (item_valid),
        .item_pop        (item_pop),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .valid_count     (valid_count),
        .mean_value      (mean_value),
        .std_deviation   (std_deviation),
        .min_value       (min_value),
        .max_value       (max_value),
        .set_empty       (set_empty),
        .count_saturated (count_saturated)
    );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for running_statistics_accumulator.
// It predicts each set's statistics from accepted sample transactions and
// compares every result transaction. Depends on src/rsa_pkg.sv and the top level RTL.
`timescale 1ns / 1ps

module tb_top;
    import rsa_pkg::*;

    localparam int SAT_COUNT  = (1 << DEF_COUNT_BITS) - 1;
    localparam int STALL_CAP  = 5000;
    localparam int DRAIN_WAIT = 400;
    localparam int QUIET_TAIL = 40;

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // One sample transaction waiting to be driven.
    typedef struct {
        logic [SAMPLE_W-1:0] value;
        logic                missing;
        logic                last;
    } sample_txn_t;

    // One set of statistics as the block should report it.
    typedef struct {
        logic [COUNT_W-1:0]         count;
        logic signed [SAMPLE_W-1:0] mean;
        logic [STD_W-1:0]           stddev;
        logic signed [SAMPLE_W-1:0] minimum;
        logic signed [SAMPLE_W-1:0] maximum;
        logic                       empty;
        logic                       saturated;
    } set_stats_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_ready;
    logic [SAMPLE_W-1:0] sample = '0;
    logic sample_missing = 1'b0;
    logic last_of_set = 1'b0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic [COUNT_W-1:0] valid_count;
    logic signed [SAMPLE_W-1:0] mean_value;
    logic [STD_W-1:0] std_deviation;
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [SAMPLE_W-1:0] max_value;
    logic set_empty;
    logic count_saturated;

    sample_txn_t pending_samples[$];
    set_stats_t  expected_stats[$];
    int          error_count = 0;
    bit          quiet_tail = 1'b0;
    int          send_gap = 0;
    int          recv_stall = 0;
    int          idle_cycles = 0;

    // Running state of the set being collected.
    logic [COUNT_W-1:0]         acc_count;
    longint                     acc_total;
    logic [63:0]                acc_squares;
    logic signed [SAMPLE_W-1:0] acc_min;
    logic signed [SAMPLE_W-1:0] acc_max;
    logic                       acc_overflow;

    running_statistics_accumulator i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .sample         (sample),
        .sample_missing (sample_missing),
        .last_of_set    (last_of_set),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .valid_count    (valid_count),
        .mean_value     (mean_value),
        .std_deviation  (std_deviation),
        .min_value      (min_value),
        .max_value      (max_value),
        .set_empty      (set_empty),
        .count_saturated(count_saturated)
    );

    // Clock generation.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Clear the running set state.
    function automatic void clear_set();
        acc_count    = '0;
        acc_total    = 0;
        acc_squares  = '0;
        acc_min      = SMP_MAX;
        acc_max      = SMP_MIN;
        acc_overflow = 1'b0;
    endfunction

    // Floor square root of a 64-bit value, one result bit per step.
    function automatic logic [63:0] floor_root(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if ({64'd0, trial} * {64'd0, trial} <= {64'd0, x})
                root = trial;
        end
        return root;
    endfunction

    // Sample standard deviation of the running set, saturated to the port width.
    function automatic logic [STD_W-1:0] set_deviation();
        logic [127:0] scaled_sq;
        logic [127:0] sum_sq;
        logic [127:0] quotient;
        logic [63:0]  mag;
        logic [63:0]  root;
        if (acc_count <= 1)
            return '0;
        mag       = (acc_total < 0) ? 64'(-acc_total) : 64'(acc_total);
        scaled_sq = 128'(acc_count) * 128'(acc_squares);
        sum_sq    = 128'(mag) * 128'(mag);
        if (scaled_sq <= sum_sq)
            return '0;
        quotient = (scaled_sq - sum_sq) / (128'(acc_count) * 128'(acc_count - 1));
        if (quotient[63:0] == 0)
            return '0;
        root = floor_root(quotient[63:0]);
        return (root > 64'(STD_MAX)) ? STD_MAX : root[STD_W-1:0];
    endfunction

    // Fold one sample transaction into the set; queue the statistics on a closing one.
    function automatic void absorb_sample(sample_txn_t t);
        set_stats_t s;
        logic signed [SAMPLE_W-1:0] v;
        longint mean;
        v = t.value;
        if (!t.missing)
        begin
            if (acc_count == COUNT_W'(SAT_COUNT))
                acc_overflow = 1'b1;
            else
            begin
                acc_count++;
                acc_total   += longint'(v);
                acc_squares += 64'(longint'(v) * longint'(v));
                if (v < acc_min)
                    acc_min = v;
                if (v > acc_max)
                    acc_max = v;
            end
        end
        if (t.last)
        begin
            mean = (acc_count != 0) ? acc_total / longint'(acc_count) : 0;
            s.count     = acc_count;
            s.mean      = mean[SAMPLE_W-1:0];
            s.stddev    = set_deviation();
            s.minimum   = acc_min;
            s.maximum   = acc_max;
            s.empty     = (acc_count == 0);
            s.saturated = acc_overflow;
            expected_stats.push_back(s);
            clear_set();
        end
    endfunction

    function automatic void add_sample(logic [SAMPLE_W-1:0] v, logic missing, logic last);
        sample_txn_t t;
        t.value   = v;
        t.missing = missing;
        t.last    = last;
        pending_samples.push_back(t);
    endfunction

    // Random sample value, biased toward the extremes and small magnitudes.
    function automatic logic [SAMPLE_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return SAMPLE_W'($signed($urandom_range(0, 2000)) - 1000);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Sample driver: holds a transaction until it is taken, with random gaps.
    always @(posedge clk)
    begin
        if (rst_n && (!sample_valid || sample_ready))
        begin
            if (send_gap > 0)
            begin
                sample_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_samples.size() > 0)
            begin
                sample_txn_t t;
                t = pending_samples.pop_front();
                sample_valid   <= 1'b1;
                sample         <= t.value;
                sample_missing <= t.missing;
                last_of_set    <= t.last;
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 5);
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // Result ready with random stall bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (recv_stall > 0)
            begin
                result_ready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end
            else
            begin
                result_ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                    recv_stall <= $urandom_range(1, 5);
            end
        end
    end

    // Monitor: checks result transactions, then predicts from sample transactions.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (expected_stats.size() == 0)
                begin
                    $error("unexpected result transaction");
                    error_count++;
                end
                else
                begin
                    set_stats_t e;
                    e = expected_stats.pop_front();
                    if (valid_count !== e.count)
                    begin
                        $error("valid_count: expected %0d, got %0d", e.count, valid_count);
                        error_count++;
                    end
                    if (mean_value !== e.mean)
                    begin
                        $error("mean_value: expected %0d, got %0d", e.mean, mean_value);
                        error_count++;
                    end
                    if (std_deviation !== e.stddev)
                    begin
                        $error("std_deviation: expected %0d, got %0d", e.stddev,
                               std_deviation);
                        error_count++;
                    end
                    if (min_value !== e.minimum)
                    begin
                        $error("min_value: expected %0d, got %0d", e.minimum, min_value);
                        error_count++;
                    end
                    if (max_value !== e.maximum)
                    begin
                        $error("max_value: expected %0d, got %0d", e.maximum, max_value);
                        error_count++;
                    end
                    if (set_empty !== e.empty)
                    begin
                        $error("set_empty: expected %0b, got %0b", e.empty, set_empty);
                        error_count++;
                    end
                    if (count_saturated !== e.saturated)
                    begin
                        $error("count_saturated: expected %0b, got %0b", e.saturated,
                               count_saturated);
                        error_count++;
                    end
                end
            end
            if (sample_valid && sample_ready)
            begin
                sample_txn_t t;
                t.value   = sample;
                t.missing = sample_missing;
                t.last    = last_of_set;
                absorb_sample(t);
            end
            if ((sample_valid && sample_ready) || (result_valid && result_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_CAP)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int made;
        int len;
        clear_set();

        // Directed sets: empty, single extreme, saturated deviation, flat set,
        // missing samples including on the closing item, negative mean rounding.
        add_sample(SMP_MAX, 1'b1, 1'b1);
        add_sample(SMP_MAX, 1'b0, 1'b1);
        add_sample(SMP_MIN, 1'b0, 1'b1);
        add_sample(SMP_MIN, 1'b0, 1'b0);
        add_sample(SMP_MAX, 1'b0, 1'b1);
        add_sample(SAMPLE_W'(100), 1'b0, 1'b0);
        add_sample(SAMPLE_W'(100), 1'b0, 1'b0);
        add_sample(SAMPLE_W'(100), 1'b0, 1'b1);
        add_sample(SAMPLE_W'(-5), 1'b0, 1'b0);
        add_sample(SAMPLE_W'(7), 1'b1, 1'b0);
        add_sample(SAMPLE_W'(9), 1'b0, 1'b0);
        add_sample(SAMPLE_W'(1234), 1'b1, 1'b1);
        add_sample(SAMPLE_W'(-3), 1'b0, 1'b0);
        add_sample(SAMPLE_W'(-4), 1'b0, 1'b1);
        add_sample('0, 1'b0, 1'b1);
        add_sample(SAMPLE_W'(-1), 1'b0, 1'b0);
        add_sample(SAMPLE_W'(1), 1'b0, 1'b1);

        // Random sets, mostly short, a few long.
        made = 0;
        while (made < 400)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
                add_sample(random_value(), $urandom_range(0, 5) == 0, i == len - 1);
            made += len;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_samples.size() < QUIET_TAIL);
        quiet_tail = 1'b1;
        wait (pending_samples.size() == 0);
        @(posedge clk);
        while (sample_valid)
            @(posedge clk);
        while (expected_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
